FILE: design/assert_macros.svh
// Assertion macros used by the design files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante -> cons");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante => cons");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: design/rcbp_pkg.sv
// Package: byte codes, request codes, widths and helpers of the command byte parser.
package rcbp_pkg;

   localparam int BYTE_W          = 8;
   localparam int GAIN_IDX_W      = 4;
   localparam int GAIN_VAL_W      = 32;
   localparam int FRAME_LEN_MAX_D = 64;

   // Frame delimiters and frame kinds
   localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h7B;  // '{'
   localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h7D;  // '}'
   localparam logic [BYTE_W-1:0] CH_QUERY = 8'h51;  // 'Q'
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
   localparam logic [BYTE_W-1:0] CH_EIGHT = 8'h38;  // '8'

   // Single-letter drive commands
   localparam logic [BYTE_W-1:0] CH_FWD      = 8'h41;  // 'A'
   localparam logic [BYTE_W-1:0] CH_REV      = 8'h45;  // 'E'
   localparam logic [BYTE_W-1:0] CH_RIGHT_LO = 8'h42;  // 'B'
   localparam logic [BYTE_W-1:0] CH_RIGHT_HI = 8'h44;  // 'D'
   localparam logic [BYTE_W-1:0] CH_LEFT_LO  = 8'h46;  // 'F'
   localparam logic [BYTE_W-1:0] CH_LEFT_HI  = 8'h48;  // 'H'

   // Request letters at frame position 3
   localparam logic [BYTE_W-1:0] CH_REQ_PARAMS  = 8'h50;  // 'P'
   localparam logic [BYTE_W-1:0] CH_REQ_READ    = 8'h52;  // 'R'
   localparam logic [BYTE_W-1:0] CH_REQ_DEFAULT = 8'h44;  // 'D'
   localparam logic [BYTE_W-1:0] CH_REQ_WRITE   = 8'h57;  // 'W'
   localparam logic [BYTE_W-1:0] CH_REQ_REBOOT  = 8'h42;  // 'B'
   localparam logic [BYTE_W-1:0] CH_REQ_BAL     = 8'h53;  // 'S'

   typedef enum logic [2:0] {
      REQ_NONE     = 3'd0,
      REQ_PARAMS   = 3'd1,
      REQ_FLASH_RD = 3'd2,
      REQ_DEFAULTS = 3'd3,
      REQ_FLASH_WR = 3'd4,
      REQ_REBOOT   = 3'd5,
      REQ_SET_BAL  = 3'd6
   } req_code_type;

   typedef struct packed {
      logic                  drive_forward;
      logic                  drive_backward;
      logic                  steer_right;
      logic                  steer_left;
      logic                  frame_end;
      req_code_type          request_code;
      logic                  gain_write;
      logic [GAIN_IDX_W-1:0] gain_index;
      logic [GAIN_VAL_W-1:0] gain_value;
   } rsp_type;

   function automatic req_code_type request_of(input logic [BYTE_W-1:0] r);
      req_code_type code;
      unique case (r)
         CH_REQ_PARAMS:  code = REQ_PARAMS;
         CH_REQ_READ:    code = REQ_FLASH_RD;
         CH_REQ_DEFAULT: code = REQ_DEFAULTS;
         CH_REQ_WRITE:   code = REQ_FLASH_WR;
         CH_REQ_REBOOT:  code = REQ_REBOOT;
         CH_REQ_BAL:     code = REQ_SET_BAL;
         default:        code = REQ_NONE;
      endcase
      return code;
   endfunction

endpackage

FILE: design/remote_command_byte_parser_top.sv
// Top level of the remote command byte parser: drive flags, frame capture, result skid.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_stall  | req_rx_byte
//   rsp     | out       | rsp_valid/rsp_stall  | drive/steer flags, frame_end, request_code,
//           |           |                      | gain_write, gain_index, gain_value
//
// Each request is decoded in the cycle it is accepted; its result is registered before it
// shows on rsp. One request per cycle is taken, limited only by the two-entry result buffer
// (output register plus skid register): req_stall rises only when both are full.
// Reset (synchronous, active high) closes any frame, clears the drive flags and empties
// the result buffer. A stalled result holds on the rsp ports until taken.
`include "assert_macros.svh"

module remote_command_byte_parser_top #(
   parameter int FRAME_LEN_MAX = rcbp_pkg::FRAME_LEN_MAX_D
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [rcbp_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_drive_forward,
   output logic                              rsp_drive_backward,
   output logic                              rsp_steer_right,
   output logic                              rsp_steer_left,
   output logic                              rsp_frame_end,
   output logic [2:0]                        rsp_request_code,
   output logic                              rsp_gain_write,
   output logic [rcbp_pkg::GAIN_IDX_W-1:0]   rsp_gain_index,
   output logic [rcbp_pkg::GAIN_VAL_W-1:0]   rsp_gain_value
);
   import rcbp_pkg::*;

   // Position counts up to FRAME_LEN_MAX itself, where capture stops.
   localparam int PosW = $clog2(FRAME_LEN_MAX + 1);

   // Frame and drive state
   logic                  in_frame_ff, in_frame_in;
   logic [PosW-1:0]       pos_ff, pos_in;
   logic [BYTE_W-1:0]     kind_ff, kind_in;
   logic [BYTE_W-1:0]     reqb_ff, reqb_in;
   logic [GAIN_VAL_W-1:0] acc_ff, acc_in;
   logic                  fwd_ff, fwd_in;
   logic                  bwd_ff, bwd_in;

   // Result buffer: output register plus skid register
   rsp_type               out_ff, skid_ff, result;
   logic                  rsp_valid_ff, skid_valid_ff;

   logic                  accept;
   logic                  out_free;
   logic                  open_frame;
   logic                  capture;
   logic [BYTE_W-1:0]     digit;
   logic [GAIN_VAL_W-1:0] acc_times10;

   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Decode one byte against the current frame state.
   assign digit       = req_rx_byte - CH_ZERO;
   assign acc_times10 = (acc_ff << 3) + (acc_ff << 1);
   // Outside a frame the capture fields are already cleared, so an opening
   // brace starts capturing at position 0 from the held state.
   assign open_frame  = (req_rx_byte == CH_OPEN) && !in_frame_ff;
   assign capture     = (req_rx_byte != CH_CLOSE) && (in_frame_ff || open_frame)
                        && (pos_ff < PosW'(FRAME_LEN_MAX));

   always_comb begin
      in_frame_in = in_frame_ff;
      pos_in      = pos_ff;
      kind_in     = kind_ff;
      reqb_in     = reqb_ff;
      acc_in      = acc_ff;
      fwd_in      = fwd_ff;
      bwd_in      = bwd_ff;

      result.steer_right  = (req_rx_byte >= CH_RIGHT_LO) && (req_rx_byte <= CH_RIGHT_HI);
      result.steer_left   = (req_rx_byte >= CH_LEFT_LO) && (req_rx_byte <= CH_LEFT_HI);
      result.frame_end    = 1'b0;
      result.request_code = REQ_NONE;
      result.gain_write   = 1'b0;
      result.gain_index   = '0;
      result.gain_value   = '0;

      // Drive letters are honored everywhere, also inside a frame.
      if (req_rx_byte == CH_FWD) begin
         fwd_in = 1'b1;
         bwd_in = 1'b0;
      end else if (req_rx_byte == CH_REV) begin
         fwd_in = 1'b0;
         bwd_in = 1'b1;
      end

      if (req_rx_byte == CH_CLOSE) begin
         // A close brace with no open frame is dropped.
         if (in_frame_ff) begin
            result.frame_end = 1'b1;
            if (kind_ff == CH_QUERY) begin
               result.request_code = request_of(reqb_ff);
            end else if (kind_ff >= CH_ZERO && kind_ff <= CH_EIGHT) begin
               result.gain_write = 1'b1;
               result.gain_index = GAIN_IDX_W'(kind_ff - CH_ZERO);
               result.gain_value = acc_ff;
            end
            in_frame_in = 1'b0;
            pos_in      = '0;
            kind_in     = '0;
            reqb_in     = '0;
            acc_in      = '0;
         end
      end else begin
         if (open_frame) begin
            in_frame_in = 1'b1;
         end
         if (capture) begin
            if (pos_ff == PosW'(1)) begin
               kind_in = req_rx_byte;
            end
            if (pos_ff == PosW'(3)) begin
               reqb_in = req_rx_byte;
            end
            if (pos_ff >= PosW'(3)) begin
               acc_in = acc_times10 + GAIN_VAL_W'(digit);
            end
            pos_in = pos_ff + PosW'(1);
         end
      end

      result.drive_forward  = fwd_in;
      result.drive_backward = bwd_in;
   end

   // Frame state: advance on every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         pos_ff      <= '0;
         kind_ff     <= '0;
         reqb_ff     <= '0;
         acc_ff      <= '0;
         fwd_ff      <= 1'b0;
         bwd_ff      <= 1'b0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         pos_ff      <= pos_in;
         kind_ff     <= kind_in;
         reqb_ff     <= reqb_in;
         acc_ff      <= acc_in;
         fwd_ff      <= fwd_in;
         bwd_ff      <= bwd_in;
      end
   end

   // Result buffer: refill the output register from skid first, else from the
   // new request; park the new request in skid while the output is stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            out_ff <= skid_ff;
         end else if (accept) begin
            out_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_drive_forward  = out_ff.drive_forward;
   assign rsp_drive_backward = out_ff.drive_backward;
   assign rsp_steer_right    = out_ff.steer_right;
   assign rsp_steer_left     = out_ff.steer_left;
   assign rsp_frame_end      = out_ff.frame_end;
   assign rsp_request_code   = out_ff.request_code;
   assign rsp_gain_write     = out_ff.gain_write;
   assign rsp_gain_index     = out_ff.gain_index;
   assign rsp_gain_value     = out_ff.gain_value;

   // Skid register only fills behind a held output register.
   `ASSERT_IMPLIES(a_skid_behind_out, clock, reset, skid_valid_ff, rsp_valid_ff)
   // Outside a frame the capture position stays at zero.
   `ASSERT_IMPLIES(a_idle_pos_zero, clock, reset, !in_frame_ff, pos_ff == '0)
   // Forward and backward are never driven together.
   `ASSERT_IMPLIES(a_drive_excl, clock, reset, fwd_ff, !bwd_ff)
   // A gain write only comes with the frame close.
   `ASSERT_IMPLIES(a_gain_on_close, clock, reset, rsp_valid_ff && out_ff.gain_write,
                   out_ff.frame_end)

endmodule
